// ===== src/pcx_rle_plane_decoder_unit_assert.svh =====
// Assertion macros for the PCX run-length plane decoder.
// Used by the checker module; needs nothing else.
`ifndef PCX_RLE_PLANE_DECODER_UNIT_ASSERT_SVH
`define PCX_RLE_PLANE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PCX_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pcx decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define PCX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pcx decoder: next-cycle check failed");

`endif

// ===== src/pcxrle_pkg.sv =====
// Shared types and constants of the PCX run-length plane decoder.
// No dependencies.
package pcxrle_pkg;

  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 6;
  localparam int ADDR_W      = 30;
  localparam int LINE_CFG_W  = 14;
  localparam int PLANE_CFG_W = 3;
  localparam int ROW_CFG_W   = 15;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_IDX_W   = 2;

  localparam int DEF_MAX_LINE_BYTES = 16384;
  localparam int DEF_MAX_ROWS       = 16384;
  localparam int DEF_MAX_PLANES     = 4;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 2;

  // Run code: both top bits set, count in the low six bits.
  localparam logic [1:0] RUN_MARK = 2'b11;

  localparam logic                   RST_COMPRESSED     = 1'b1;
  localparam logic [LINE_CFG_W-1:0]  RST_BYTES_PER_LINE = 14'd80;
  localparam logic [PLANE_CFG_W-1:0] RST_PLANE_COUNT    = 3'd1;
  localparam logic [ROW_CFG_W-1:0]   RST_ROW_COUNT      = 15'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPRESSED     = 2'd0,
    CFG_BYTES_PER_LINE = 2'd1,
    CFG_PLANE_COUNT    = 2'd2,
    CFG_ROW_COUNT      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                   compressed;
    logic [LINE_CFG_W-1:0]  bytes_per_line;
    logic [PLANE_CFG_W-1:0] plane_count;
    logic [ROW_CFG_W-1:0]   row_count;
  } cfg_t;

  // One write job: value repeated count times.
  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

// ===== src/pcxrle_front.sv =====
// Front end: classifies stream bytes into literal and run commands.
// Depends on pcxrle_pkg.
module pcxrle_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic                         compressed_i,
  input  logic                         accept_i,
  input  logic [pcxrle_pkg::BYTE_W-1:0] byte_i,
  output logic                         cmd_valid_o,
  output pcxrle_pkg::cmd_t             cmd_o
);

  logic                           await_q, await_d;
  logic [pcxrle_pkg::COUNT_W-1:0] pend_q, pend_d;

  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_o.value = byte_i;
    cmd_o.count = pcxrle_pkg::COUNT_W'(1);
    await_d     = await_q;
    pend_d      = pend_q;
    if (restart_i) begin
      await_d = 1'b0;
      pend_d  = '0;
    end else if (accept_i) begin
      priority if (!compressed_i) begin
        cmd_valid_o = 1'b1;
      end else if (await_q) begin
        // value byte of a run: issue with the held count
        cmd_valid_o = 1'b1;
        cmd_o.count = pend_q;
        await_d     = 1'b0;
        pend_d      = '0;
      end else if (byte_i[7:6] == pcxrle_pkg::RUN_MARK) begin
        pend_d  = byte_i[pcxrle_pkg::COUNT_W-1:0];
        await_d = 1'b1;
      end else begin
        cmd_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b0;
      pend_q  <= '0;
    end else begin
      await_q <= await_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ===== src/pcxrle_cmd_fifo.sv =====
// Short command queue between front and back end.
// Depends on pcxrle_pkg.
module pcxrle_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             flush_i,
  input  logic             push_i,
  input  pcxrle_pkg::cmd_t data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output pcxrle_pkg::cmd_t data_o
);

  localparam int PtrW = (pcxrle_pkg::CMD_DEPTH > 1) ? $clog2(pcxrle_pkg::CMD_DEPTH) : 1;
  localparam int CntW = $clog2(pcxrle_pkg::CMD_DEPTH + 1);

  pcxrle_pkg::cmd_t mem_q [pcxrle_pkg::CMD_DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(pcxrle_pkg::CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(pcxrle_pkg::CMD_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (flush_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= ptr_inc(wr_q);
      if (pop_i && valid_o) rd_q <= ptr_inc(rd_q);
      unique case ({push_i && !full_o, pop_i && valid_o})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/pcxrle_back.sv =====
// Back end: walks write position; one buffer write per cycle unless stalled.
// Depends on pcxrle_pkg.
module pcxrle_back #(
  parameter int MAX_LINE_BYTES = pcxrle_pkg::DEF_MAX_LINE_BYTES,
  parameter int MAX_ROWS       = pcxrle_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES     = pcxrle_pkg::DEF_MAX_PLANES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            flush_i,
  input  logic                            restart_i,
  input  pcxrle_pkg::cfg_t                cfg_i,
  input  logic                            head_valid_i,
  input  pcxrle_pkg::cmd_t                head_i,
  output logic                            head_pop_o,
  input  logic                            pop_i,
  output logic                            empty_o,
  output logic [pcxrle_pkg::BYTE_W-1:0]   pixel_value_o,
  output logic [pcxrle_pkg::ADDR_W-1:0]   buffer_address_o,
  output logic                            last_of_run_o,
  output logic                            image_complete_o
);

  localparam int LineW  = $clog2(MAX_LINE_BYTES + 1);
  localparam int RowW   = $clog2(MAX_ROWS + 1);
  localparam int PlaneW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int AW     = pcxrle_pkg::ADDR_W;
  localparam int CW     = pcxrle_pkg::COUNT_W;
  localparam int PCW    = pcxrle_pkg::PLANE_CFG_W;

  logic [LineW-1:0]  eff_line;
  logic [PCW-1:0]    eff_planes;
  logic [RowW-1:0]   eff_rows;
  logic [PlaneW-1:0] top_plane;

  logic [AW-1:0]     stride_q;
  logic [LineW-1:0]  col_q, col_d;
  logic [AW-1:0]     col_off_q, col_off_d;
  logic [AW-1:0]     row_base_q, row_base_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [PlaneW-1:0] plane_q, plane_d;
  logic              finished_q, finished_d;
  logic [CW-1:0]     idx_q, idx_d;

  logic              out_valid_q;
  logic              out_ready, live, do_emit, drop, done, last_w;

  // Clamp the raw register values into the supported range.
  always_comb begin
    priority if (cfg_i.bytes_per_line == '0) eff_line = LineW'(1);
    else if (32'(cfg_i.bytes_per_line) > MAX_LINE_BYTES) eff_line = LineW'(MAX_LINE_BYTES);
    else eff_line = LineW'(cfg_i.bytes_per_line);

    priority if (cfg_i.plane_count == '0) eff_planes = PCW'(1);
    else if (32'(cfg_i.plane_count) > MAX_PLANES) eff_planes = PCW'(MAX_PLANES);
    else eff_planes = cfg_i.plane_count;

    priority if (cfg_i.row_count == '0) eff_rows = RowW'(1);
    else if (32'(cfg_i.row_count) > MAX_ROWS) eff_rows = RowW'(MAX_ROWS);
    else eff_rows = RowW'(cfg_i.row_count);

    top_plane = PlaneW'(eff_planes - PCW'(1));
  end

  assign out_ready  = !out_valid_q || pop_i;
  assign live       = head_valid_i && !restart_i;
  assign drop       = live && (finished_q || head_i.count == '0);
  assign do_emit    = live && !finished_q && head_i.count != '0 && out_ready;
  assign head_pop_o = drop || (do_emit && last_w);

  always_comb begin
    col_d      = col_q;
    col_off_d  = col_off_q;
    row_base_d = row_base_q;
    row_d      = row_q;
    plane_d    = plane_q;
    finished_d = finished_q;
    idx_d      = idx_q;
    done       = 1'b0;
    if (restart_i) begin
      col_d      = '0;
      col_off_d  = '0;
      row_base_d = '0;
      row_d      = '0;
      plane_d    = top_plane;
      finished_d = 1'b0;
      idx_d      = '0;
    end else if (do_emit) begin
      if (col_q + LineW'(1) >= eff_line) begin
        col_d     = '0;
        col_off_d = '0;
        if (plane_q == '0) begin
          // line done on the lowest plane: advance to the next row
          plane_d    = top_plane;
          row_d      = row_q + RowW'(1);
          row_base_d = row_base_q + stride_q;
          if (row_q + RowW'(1) >= eff_rows) begin
            finished_d = 1'b1;
            done       = 1'b1;
            row_d      = '0;
            row_base_d = '0;
          end
        end else begin
          plane_d = plane_q - PlaneW'(1);
        end
      end else begin
        col_d     = col_q + LineW'(1);
        col_off_d = col_off_q + AW'(eff_planes);
      end
      idx_d = ((idx_q + CW'(1) == head_i.count) || done) ? '0 : idx_q + CW'(1);
    end else if (drop) begin
      idx_d = '0;
    end
  end

  assign last_w = (idx_q + CW'(1) == head_i.count) || done;

  // Row stride changes only with configuration; register it off the add path.
  always_ff @(posedge clk_i) begin
    stride_q <= AW'(eff_line) * AW'(eff_planes);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      col_off_q  <= '0;
      row_base_q <= '0;
      row_q      <= '0;
      plane_q    <= '0;
      finished_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      col_q      <= col_d;
      col_off_q  <= col_off_d;
      row_base_q <= row_base_d;
      row_q      <= row_d;
      plane_q    <= plane_d;
      finished_q <= finished_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (flush_i) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      pixel_value_o    <= head_i.value;
      buffer_address_o <= row_base_q + col_off_q + AW'(plane_q);
      last_of_run_o    <= last_w;
      image_complete_o <= done;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

// ===== src/pcx_rle_plane_decoder_unit.sv =====
// Top level of the PCX run-length plane decoder.
// Depends on pcxrle_pkg, pcxrle_front, pcxrle_cmd_fifo and pcxrle_back.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------------
//   input     push / full          stream_byte_i
//   result    empty / pop          pixel_value_o, buffer_address_o,
//                                  last_of_run_o, image_complete_o
//   config    cfg_valid_i / ready  cfg_index_i, cfg_data_i
//
// A byte is classified in the cycle it is taken; a literal or run command then
// waits in a two-entry queue. The back end emits one buffer write per cycle, one
// for each byte of a run; a run code byte alone makes no write. The output
// register holds a write until it is popped; the back end stalls on it, and the
// front stalls when the command queue is full or a restart is under way.
// Reset clears all position state. A register write flushes queue and output
// and restarts decoding; full stays high for the one cycle of that restart.
module pcx_rle_plane_decoder_unit #(
  parameter int MAX_LINE_BYTES = pcxrle_pkg::DEF_MAX_LINE_BYTES,
  parameter int MAX_ROWS       = pcxrle_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES     = pcxrle_pkg::DEF_MAX_PLANES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // byte stream
  input  logic                                push,
  output logic                                full,
  input  logic [pcxrle_pkg::BYTE_W-1:0]       stream_byte_i,
  // buffer writes
  output logic                                empty,
  input  logic                                pop,
  output logic [pcxrle_pkg::BYTE_W-1:0]       pixel_value_o,
  output logic [pcxrle_pkg::ADDR_W-1:0]       buffer_address_o,
  output logic                                last_of_run_o,
  output logic                                image_complete_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  pcxrle_pkg::cfg_t cfg_q, cfg_d;
  logic             cfg_we;
  logic             restart_q;
  logic             in_accept;
  logic             q_full, q_valid, q_pop, cmd_valid;
  pcxrle_pkg::cmd_t cmd, head;

  // Configuration is always taken; any write restarts the decoder.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (pcxrle_pkg::cfg_idx_e'(cfg_index_i))
        pcxrle_pkg::CFG_COMPRESSED:     cfg_d.compressed     = cfg_data_i[0];
        pcxrle_pkg::CFG_BYTES_PER_LINE: cfg_d.bytes_per_line =
          cfg_data_i[pcxrle_pkg::LINE_CFG_W-1:0];
        pcxrle_pkg::CFG_PLANE_COUNT:    cfg_d.plane_count    =
          cfg_data_i[pcxrle_pkg::PLANE_CFG_W-1:0];
        pcxrle_pkg::CFG_ROW_COUNT:      cfg_d.row_count      =
          cfg_data_i[pcxrle_pkg::ROW_CFG_W-1:0];
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.compressed     <= pcxrle_pkg::RST_COMPRESSED;
      cfg_q.bytes_per_line <= pcxrle_pkg::RST_BYTES_PER_LINE;
      cfg_q.plane_count    <= pcxrle_pkg::RST_PLANE_COUNT;
      cfg_q.row_count      <= pcxrle_pkg::RST_ROW_COUNT;
      restart_q            <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      restart_q <= cfg_we;
    end
  end

  // Hold off input while the queue is full or the back end restarts.
  assign full      = q_full || restart_q;
  assign in_accept = push && !full;

  pcxrle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_we),
    .compressed_i (cfg_q.compressed),
    .accept_i     (in_accept),
    .byte_i       (stream_byte_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  pcxrle_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (cfg_we),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (head)
  );

  pcxrle_back #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_ROWS       (MAX_ROWS),
    .MAX_PLANES     (MAX_PLANES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .flush_i          (cfg_we),
    .restart_i        (restart_q),
    .cfg_i            (cfg_q),
    .head_valid_i     (q_valid && !cfg_we),
    .head_i           (head),
    .head_pop_o       (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .pixel_value_o    (pixel_value_o),
    .buffer_address_o (buffer_address_o),
    .last_of_run_o    (last_of_run_o),
    .image_complete_o (image_complete_o)
  );

endmodule

// ===== src/pcxrle_checker.sv =====
// Port-level checks of the PCX run-length plane decoder, bound to its top level.
// Depends on pcxrle_pkg and pcx_rle_plane_decoder_unit_assert.svh.
`include "pcx_rle_plane_decoder_unit_assert.svh"

module pcxrle_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic [pcxrle_pkg::ADDR_W-1:0]     buffer_address_o,
  input logic                              last_of_run_o,
  input logic                              image_complete_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o
);

  // The image-closing write always ends the beat's run.
  `PCX_ASSERT_IMPL(a_complete_is_last, clk_i, rst_ni, !empty && image_complete_o, last_of_run_o)

  // Nothing follows the closing write until a restart.
  `PCX_ASSERT_NEXT(a_quiet_after_end, clk_i, rst_ni, pop && !empty && image_complete_o, empty)

  // A register write restarts: input held off, results flushed.
  `PCX_ASSERT_NEXT(a_restart_blocks, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, full && empty)

  // A waiting result holds while not popped.
  `PCX_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop && !cfg_valid_i,
                   !empty && $stable(buffer_address_o))

endmodule

bind pcx_rle_plane_decoder_unit pcxrle_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .buffer_address_o (buffer_address_o),
  .last_of_run_o    (last_of_run_o),
  .image_complete_o (image_complete_o),
  .cfg_valid_i      (cfg_valid_i),
  .cfg_ready_o      (cfg_ready_o)
);

// ===== dv/pcx_rle_plane_decoder_unit_tb.sv =====
// Self-checking testbench for pcx_rle_plane_decoder_unit: directed and random PCX streams
// against a cycle-free decode model, under random sender bursts and receiver stalls.
// Depends on pcxrle_pkg and the decoder RTL.
`timescale 1ns / 1ps

module pcx_rle_plane_decoder_unit_tb;
  import pcxrle_pkg::*;

  localparam int SETTLE_CYCLES = 10;          // covers queue, back end and output register
  localparam int WATCHDOG_NS   = 10_000_000;
  localparam int LINE_LIMIT    = DEF_MAX_LINE_BYTES;
  localparam int ROW_LIMIT     = DEF_MAX_ROWS;
  localparam int PLANE_LIMIT   = DEF_MAX_PLANES;
  // Highest byte that is a literal in compressed mode (top two bits not both set).
  localparam logic [BYTE_W-1:0] LITERAL_MAX = {2'b10, {(BYTE_W-2){1'b1}}};

  // One buffer write as it leaves the block.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              done;
  } buf_write_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  push          = 1'b0;
  logic                  full;
  logic [BYTE_W-1:0]     stream_byte_i = '0;
  logic                  empty;
  logic                  pop           = 1'b0;
  logic [BYTE_W-1:0]     pixel_value_o;
  logic [ADDR_W-1:0]     buffer_address_o;
  logic                  last_of_run_o;
  logic                  image_complete_o;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  pcx_rle_plane_decoder_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .stream_byte_i    (stream_byte_i),
    .empty            (empty),
    .pop              (pop),
    .pixel_value_o    (pixel_value_o),
    .buffer_address_o (buffer_address_o),
    .last_of_run_o    (last_of_run_o),
    .image_complete_o (image_complete_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Decode model: register copies plus write position, updated per accepted beat
  // ---------------------------------------------------------------------------
  logic                   m_compressed;
  logic [LINE_CFG_W-1:0]  m_line;
  logic [PLANE_CFG_W-1:0] m_planes;
  logic [ROW_CFG_W-1:0]   m_rows;

  logic                   m_await;      // run code seen, value byte next
  logic [COUNT_W-1:0]     m_count;
  int unsigned            m_col;
  int unsigned            m_plane;
  int unsigned            m_row;
  logic                   m_finished;   // image full, drop everything

  buf_write_t expected_writes[$];

  int n_errors  = 0;
  int n_checked = 0;
  int n_bytes   = 0;
  int n_dropped = 0;
  int n_images  = 0;
  int n_cfg     = 0;

  // Zero sizes act as one; oversize values clamp to the build limits.
  function automatic int unsigned line_len();
    if (m_line == 0) return 1;
    if (m_line > LINE_LIMIT) return LINE_LIMIT;
    return m_line;
  endfunction

  function automatic int unsigned plane_num();
    if (m_planes == 0) return 1;
    if (m_planes > PLANE_LIMIT) return PLANE_LIMIT;
    return m_planes;
  endfunction

  function automatic int unsigned row_num();
    if (m_rows == 0) return 1;
    if (m_rows > ROW_LIMIT) return ROW_LIMIT;
    return m_rows;
  endfunction

  function automatic logic [BYTE_W-1:0] run_code(input logic [COUNT_W-1:0] count);
    return {RUN_MARK, count};
  endfunction

  // Restart at row 0, column 0, highest plane, no pending run.
  task automatic restart_position();
    m_await    = 1'b0;
    m_count    = '0;
    m_col      = 0;
    m_plane    = plane_num() - 1;
    m_row      = 0;
    m_finished = 1'b0;
  endtask

  // Queue up to count writes of value; stop at the last byte of the image.
  task automatic queue_writes(input logic [BYTE_W-1:0] value, input int unsigned count);
    buf_write_t      w;
    longint unsigned a;
    int unsigned     line;
    int unsigned     planes;
    int unsigned     rows;
    logic            done;
    line   = line_len();
    planes = plane_num();
    rows   = row_num();
    for (int unsigned i = 0; i < count && !m_finished; i++) begin
      a    = (longint'(m_row) * line + m_col) * planes + m_plane;
      done = 1'b0;
      m_col++;
      if (m_col >= line) begin
        m_col = 0;
        if (m_plane == 0) begin
          m_plane = planes - 1;
          m_row++;
          if (m_row >= rows) begin
            m_finished = 1'b1;
            done       = 1'b1;
            m_row      = 0;
            n_images++;
          end
        end else begin
          m_plane--;
        end
      end
      w.value = value;
      w.addr  = a[ADDR_W-1:0];
      w.last  = (i + 1 == count) || done;
      w.done  = done;
      expected_writes.push_back(w);
    end
  endtask

  // Classify one stream byte and queue the writes it causes.
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [COUNT_W-1:0] cnt;
    if (m_finished) begin
      n_dropped++;
      return;
    end
    if (!m_compressed) begin
      queue_writes(b, 1);
    end else if (m_await) begin
      cnt     = m_count;
      m_await = 1'b0;
      m_count = '0;
      queue_writes(b, cnt);
    end else if (b[BYTE_W-1 -: 2] == RUN_MARK) begin
      m_count = b[COUNT_W-1:0];
      m_await = 1'b1;
    end else begin
      queue_writes(b, 1);
    end
  endtask

  task automatic load_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_COMPRESSED:     m_compressed = data[0];
      CFG_BYTES_PER_LINE: m_line       = data[LINE_CFG_W-1:0];
      CFG_PLANE_COUNT:    m_planes     = data[PLANE_CFG_W-1:0];
      CFG_ROW_COUNT:      m_rows       = data[ROW_CFG_W-1:0];
      default: ;
    endcase
    restart_position();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pop, with random stalls when enabled
  // ---------------------------------------------------------------------------
  logic rx_stalls     = 1'b0;
  int   rx_stall_left = 0;

  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      pop <= 1'b0;
      rx_stall_left--;
    end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      rx_stall_left = $urandom_range(0, 11);
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare each popped write with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_write();
  end

  task automatic check_write();
    buf_write_t e;
    if (expected_writes.size() == 0) begin
      $display("%0t: unexpected write, value %h addr %h last %b complete %b", $time,
               pixel_value_o, buffer_address_o, last_of_run_o, image_complete_o);
      n_errors++;
      return;
    end
    e = expected_writes.pop_front();
    n_checked++;
    if (pixel_value_o !== e.value) begin
      $display("%0t: pixel_value expected %h actual %h", $time, e.value, pixel_value_o);
      n_errors++;
    end
    if (buffer_address_o !== e.addr) begin
      $display("%0t: buffer_address expected %0d actual %0d", $time, e.addr,
               buffer_address_o);
      n_errors++;
    end
    if (last_of_run_o !== e.last) begin
      $display("%0t: last_of_run expected %b actual %b", $time, e.last, last_of_run_o);
      n_errors++;
    end
    if (image_complete_o !== e.done) begin
      $display("%0t: image_complete expected %b actual %b", $time, e.done,
               image_complete_o);
      n_errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one beat per call; push stays high across a burst, then drops
  // for a random gap when bursty mode is on.
  // ---------------------------------------------------------------------------
  logic tx_bursty  = 1'b0;
  int   burst_left = 0;

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    push          <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (full);
    decode_byte(b);
    n_bytes++;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(0, 15);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop push, wait for every expected write, then let a run code or a
  // dropped byte clear the pipeline.
  task automatic settle();
    push <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register beats only go out with the block idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    load_register(idx, data);
    n_cfg++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: literals at both ends, a zero-count run, a full 63-byte run,
  // and a value byte that looks like a run code.
  task automatic test_reset_defaults();
    rx_stalls = 1'b0;
    tx_bursty = 1'b0;
    send_byte(8'h00);
    send_byte(LITERAL_MAX);
    send_byte(run_code(6'd0));
    send_byte(8'h55);
    send_byte(run_code(6'h3f));
    send_byte(8'hff);
    send_byte(run_code(6'd1));
    send_byte(run_code(6'd3));
    settle();
  endtask

  // Short lines with oversize plane count: runs cross line and plane ends,
  // then a long run is cut at image end and later bytes drop.
  task automatic test_line_plane_walk();
    write_reg(CFG_BYTES_PER_LINE, 15'd3);
    write_reg(CFG_PLANE_COUNT, 15'd7);
    write_reg(CFG_ROW_COUNT, 15'd2);
    rx_stalls = 1'b1;
    send_byte(run_code(6'd5));
    send_byte(8'h7e);
    send_byte(run_code(6'h3f));
    send_byte(8'h81);
    send_byte(8'h12);
    send_byte(run_code(6'd2));
    settle();
  endtask

  // Zero sizes act as one; a register write abandons a pending run.
  task automatic test_degenerate_sizes();
    write_reg(CFG_BYTES_PER_LINE, 15'd0);
    write_reg(CFG_PLANE_COUNT, 15'd0);
    write_reg(CFG_ROW_COUNT, 15'd0);
    tx_bursty = 1'b1;
    send_byte(run_code(6'd2));
    send_byte(8'ha5);
    send_byte(8'h00);
    write_reg(CFG_PLANE_COUNT, 15'd5);
    send_byte(run_code(6'd4));
    send_byte(8'h3c);
    write_reg(CFG_COMPRESSED, 15'h0001);
    send_byte(run_code(6'd7));
    write_reg(CFG_COMPRESSED, 15'h7fff);
    send_byte(8'h11);
    settle();
  endtask

  // Pass-through mode takes run-code bytes as plain data.
  task automatic test_uncompressed();
    write_reg(CFG_COMPRESSED, 15'h7ffe);
    write_reg(CFG_BYTES_PER_LINE, 15'd2);
    write_reg(CFG_PLANE_COUNT, 15'd2);
    write_reg(CFG_ROW_COUNT, 15'd1);
    send_byte(run_code(6'd5));
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h3f);
    write_reg(CFG_COMPRESSED, 15'h0001);
  endtask

  // Widest line, most planes, row count above the limit and at it.
  task automatic test_large_sizes();
    write_reg(CFG_BYTES_PER_LINE, 15'h3fff);
    write_reg(CFG_PLANE_COUNT, 15'd4);
    write_reg(CFG_ROW_COUNT, 15'h7fff);
    send_byte(run_code(6'h3f));
    send_byte(8'h5a);
    write_reg(CFG_ROW_COUNT, 15'd16384);
    send_byte(8'h40);
    settle();
  endtask

  // Random phases: each picks new registers and handshake pressure, then sends mostly
  // well-formed run pairs and literals with some noise, or raw bytes if uncompressed.
  task automatic test_random_stream();
    int                     sent;
    logic                   mode;
    logic [LINE_CFG_W-1:0]  line;
    logic [PLANE_CFG_W-1:0] planes;
    logic [ROW_CFG_W-1:0]   rows;
    for (int phase = 0; phase < 6; phase++) begin
      tx_bursty = (phase != 0);
      rx_stalls = (phase % 2 == 1) || (phase == 4);
      mode      = (phase % 3 != 2);
      line      = ($urandom_range(0, 5) == 0) ? 14'($urandom) : 14'($urandom_range(0, 24));
      planes    = 3'($urandom);
      rows      = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 5));
      write_reg(CFG_COMPRESSED, {14'($urandom), mode});
      write_reg(CFG_BYTES_PER_LINE, {1'($urandom), line});
      write_reg(CFG_PLANE_COUNT, {12'($urandom), planes});
      write_reg(CFG_ROW_COUNT, rows);
      sent = 0;
      while (sent < 52) begin
        if (m_finished) begin
          // Feed a few bytes past the image end, then restart with a new height.
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
          write_reg(CFG_ROW_COUNT, 15'($urandom_range(0, 6)));
        end else if (!m_compressed) begin
          send_byte(8'($urandom));
          sent++;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              send_byte(run_code(6'($urandom)));
              send_byte(8'($urandom));
              sent += 2;
            end
            6, 7, 8: begin
              send_byte(8'($urandom_range(0, LITERAL_MAX)));
              sent++;
            end
            default: begin
              send_byte(8'($urandom));
              sent++;
            end
          endcase
        end
      end
      // Leave a run code hanging now and then; the next register write drops it.
      if (m_compressed && !m_finished && $urandom_range(0, 1) == 1) begin
        send_byte(run_code(6'($urandom)));
      end
    end
    settle();
  endtask

  initial begin
    m_compressed = RST_COMPRESSED;
    m_line       = RST_BYTES_PER_LINE;
    m_planes     = RST_PLANE_COUNT;
    m_rows       = RST_ROW_COUNT;
    restart_position();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_line_plane_walk();
    test_degenerate_sizes();
    test_uncompressed();
    test_large_sizes();
    test_random_stream();

    $display("Run covered %0d stream bytes (%0d past image end), %0d register writes,",
             n_bytes, n_dropped, n_cfg);
    $display("and %0d buffer writes checked across %0d completed images.", n_checked,
             n_images);
    if (n_errors == 0 && expected_writes.size() == 0) begin
      $display("pcx_rle_plane_decoder_unit_tb: PASS");
    end else begin
      $display("pcx_rle_plane_decoder_unit_tb: FAIL");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #(WATCHDOG_NS);
    $display("Timed out with %0d writes still expected.", expected_writes.size());
    $display("pcx_rle_plane_decoder_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/pcxrle_pkg.sv
src/pcxrle_front.sv
src/pcxrle_cmd_fifo.sv
src/pcxrle_back.sv
src/pcx_rle_plane_decoder_unit.sv
src/pcxrle_checker.sv
dv/pcx_rle_plane_decoder_unit_tb.sv
